/* rtl/slt_pkg.sv */
// Package for the source line tokenizer: beat types, token and error codes,
// character constants and byte classification helpers. No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int LINE_WIDTH = 16;
    localparam int COL_WIDTH  = 12;
    localparam int MAX_RES    = 3;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_NUL    = 8'd0;

    typedef enum logic [1:0] {
        K_LEXEME = 2'd0,
        K_DONE   = 2'd1,
        K_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        TT_IDENT  = 4'd0,
        TT_INT    = 4'd1,
        TT_FLOAT  = 4'd2,
        TT_STRING = 4'd3,
        TT_OP     = 4'd4,
        TT_LBRACE = 4'd5,
        TT_RBRACE = 4'd6,
        TT_LPAREN = 4'd7,
        TT_RPAREN = 4'd8,
        TT_SEMI   = 4'd9
    } t_tok;

    typedef enum logic [1:0] {
        E_BAD_NUMBER = 2'd0,
        E_BAD_ESCAPE = 2'd1,
        E_UNCLOSED   = 2'd2,
        E_UNEXPECTED = 2'd3
    } t_err;

    typedef struct packed {
        logic       action;
        logic [7:0] char_byte;
    } t_in_beat;

    typedef struct packed {
        t_kind                 kind;
        t_tok                  token_type;
        logic [7:0]            lexeme_byte;
        logic [LINE_WIDTH-1:0] line_number;
        logic [COL_WIDTH-1:0]  column_number;
        t_err                  error_code;
        logic                  last;
    } t_out_beat;

    typedef struct packed {
        t_out_beat [MAX_RES-1:0] res;
        logic [1:0]              n;
    } t_bundle;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c == CH_TAB) || (c == 8'd12) || (c == 8'd11) || (c == CH_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

/* rtl/source_line_tokenizer_core.sv */
// Top level of the source line tokenizer: lexer state, result generation
// and a small buffer of result groups. Depends on slt_pkg.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                   | Payload
// input    | in        | i_in_valid / o_in_ready     | i_in_data  (t_in_beat)
// result   | out       | o_out_valid / i_out_ready   | o_out_data (t_out_beat)
//
// One input beat is taken per cycle while the four-entry result group buffer
// has room; its zero to three results are formed in the same cycle.
// Result beats leave one per cycle while i_out_ready is high, so a stream
// sustains one input per cycle when it averages at most one result per input.
// Reset is synchronous and active low and returns line and column to 1.
// A stalled output fills the buffer, after which input ready drops.

module source_line_tokenizer_core
    import slt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_NEG,
        M_DBL,
        M_STRING,
        M_ESCAPE,
        M_COMMENT,
        M_ERROR
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [LINE_WIDTH-1:0] r_line, n_line;
    logic [COL_WIDTH-1:0]  r_col, n_col;
    logic [COL_WIDTH-1:0]  r_tstart, n_tstart;
    logic [1:0]            r_dots, n_dots;
    logic                  r_lastdot, n_lastdot;

    t_bundle               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wptr, r_rptr;
    logic [FIFO_AW:0]      r_count;
    logic [1:0]            r_sub;

    t_out_beat [MAX_RES-1:0] res;
    logic [1:0]            cnt;
    logic                  fin;
    logic                  fin_ok;
    logic                  in_acc;
    logic                  out_acc;
    logic                  push;
    logic                  pop;
    logic [7:0]            c;
    t_bundle               head;

    function automatic t_out_beat mk(input t_kind k, input t_tok ty, input logic [7:0] b,
                                     input logic [LINE_WIDTH-1:0] ln,
                                     input logic [COL_WIDTH-1:0] col, input t_err e);
        t_out_beat o;
        o.kind          = k;
        o.token_type    = ty;
        o.lexeme_byte   = b;
        o.line_number   = ln;
        o.column_number = col;
        o.error_code    = e;
        o.last          = 1'b0;
        return o;
    endfunction

    assign o_in_ready  = (r_count != (FIFO_AW+1)'(FIFO_DEPTH));
    assign in_acc      = i_in_valid && o_in_ready;
    assign c           = i_in_data.char_byte;
    assign head        = r_fifo[r_rptr];
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = head.res[r_sub];
    assign out_acc     = o_out_valid && i_out_ready;
    assign pop         = out_acc && (r_sub == head.n - 2'd1);
    assign push        = in_acc && (cnt != 2'd0);

    always_comb begin
        n_mode    = r_mode;
        n_line    = r_line;
        n_col     = r_col;
        n_tstart  = r_tstart;
        n_dots    = r_dots;
        n_lastdot = r_lastdot;
        res       = '0;
        cnt       = 2'd0;
        fin       = 1'b0;
        fin_ok    = 1'b1;
        if (in_acc && r_mode != M_ERROR) begin
            if (i_in_data.action) begin
                fin = 1'b1;
            end else begin
                if (r_col != '1) begin
                    n_col = r_col + COL_WIDTH'(1);
                end
                unique case (r_mode)
                    M_IDENT: begin
                        if (is_letter(c) || is_digit(c)) begin
                            res[cnt] = mk(K_LEXEME, TT_IDENT, c, r_line, r_col, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(c)) begin
                            res[cnt] = mk(K_LEXEME, TT_INT, c, r_line, r_col, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            n_lastdot = 1'b0;
                        end else if (c == CH_DOT) begin
                            res[cnt] = mk(K_LEXEME, TT_INT, c, r_line, r_col, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            if (r_dots != 2'd2) begin
                                n_dots = r_dots + 2'd1;
                            end
                            n_lastdot = 1'b1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    M_NEG: begin
                        if (is_digit(c)) begin
                            res[cnt] = mk(K_LEXEME, TT_INT, c, r_line, r_col, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            n_mode    = M_NUMBER;
                            n_dots    = 2'd0;
                            n_lastdot = 1'b0;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    M_DBL: begin
                        if (c == CH_EQ) begin
                            res[cnt] = mk(K_LEXEME, TT_OP, c, r_line, r_col, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            res[cnt] = mk(K_DONE, TT_OP, CH_NUL, r_line, r_tstart, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    M_STRING: begin
                        if (c == CH_QUOTE) begin
                            res[cnt] = mk(K_DONE, TT_STRING, CH_NUL, r_line, r_tstart,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            n_mode = M_IDLE;
                        end else if (c == CH_BSLASH) begin
                            n_mode = M_ESCAPE;
                        end else begin
                            res[cnt] = mk(K_LEXEME, TT_STRING, c, r_line, r_col, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end
                    end
                    M_ESCAPE: begin
                        n_mode = M_STRING;
                        priority if (c == CH_LOW_T) begin
                            res[cnt] = mk(K_LEXEME, TT_STRING, CH_TAB, r_line, r_col,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end else if (c == CH_LOW_R) begin
                            res[cnt] = mk(K_LEXEME, TT_STRING, CH_CR, r_line, r_col,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end else if (c == CH_LOW_N) begin
                            res[cnt] = mk(K_LEXEME, TT_STRING, CH_LF, r_line, r_col,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end else if (c == CH_QUOTE) begin
                            res[cnt] = mk(K_LEXEME, TT_STRING, CH_QUOTE, r_line, r_col,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end else if (c == CH_ZERO) begin
                            res[cnt] = mk(K_LEXEME, TT_STRING, CH_NUL, r_line, r_col,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end else begin
                            res[cnt] = mk(K_ERROR, TT_IDENT, CH_NUL, r_line, r_col,
                                          E_BAD_ESCAPE);
                            cnt = cnt + 2'd1;
                            n_mode = M_ERROR;
                        end
                    end
                    M_COMMENT: begin
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            if (fin) begin
                unique case (r_mode)
                    M_IDENT: begin
                        res[cnt] = mk(K_DONE, TT_IDENT, CH_NUL, r_line, r_tstart, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end
                    M_NUMBER: begin
                        if (r_lastdot || r_dots == 2'd2) begin
                            res[cnt] = mk(K_ERROR, TT_IDENT, CH_NUL, r_line, r_tstart,
                                          E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                            fin_ok = 1'b0;
                        end else begin
                            res[cnt] = mk(K_DONE, (r_dots == 2'd1) ? TT_FLOAT : TT_INT,
                                          CH_NUL, r_line, r_tstart, E_BAD_NUMBER);
                            cnt = cnt + 2'd1;
                        end
                    end
                    M_NEG, M_DBL: begin
                        res[cnt] = mk(K_DONE, TT_OP, CH_NUL, r_line, r_tstart, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end
                    M_STRING, M_ESCAPE: begin
                        res[cnt] = mk(K_ERROR, TT_IDENT, CH_NUL, r_line, r_tstart, E_UNCLOSED);
                        cnt = cnt + 2'd1;
                        fin_ok = 1'b0;
                    end
                    default: begin
                    end
                endcase
                n_mode = fin_ok ? M_IDLE : M_ERROR;
            end

            if (fin && fin_ok) begin
                if (i_in_data.action) begin
                    if (r_line != '1) begin
                        n_line = r_line + LINE_WIDTH'(1);
                    end
                    n_col = COL_WIDTH'(1);
                end else begin
                    n_tstart = r_col;
                    priority if (is_space(c)) begin
                    end else if (c == CH_HASH) begin
                        n_mode = M_COMMENT;
                    end else if (c == CH_LBRACE) begin
                        res[cnt] = mk(K_DONE, TT_LBRACE, CH_NUL, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end else if (c == CH_RBRACE) begin
                        res[cnt] = mk(K_DONE, TT_RBRACE, CH_NUL, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end else if (c == CH_LPAREN) begin
                        res[cnt] = mk(K_DONE, TT_LPAREN, CH_NUL, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end else if (c == CH_RPAREN) begin
                        res[cnt] = mk(K_DONE, TT_RPAREN, CH_NUL, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end else if (c == CH_SEMI) begin
                        res[cnt] = mk(K_DONE, TT_SEMI, CH_NUL, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end else if (is_letter(c)) begin
                        res[cnt] = mk(K_LEXEME, TT_IDENT, c, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDENT;
                    end else if (is_digit(c)) begin
                        res[cnt] = mk(K_LEXEME, TT_INT, c, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                        n_mode    = M_NUMBER;
                        n_dots    = 2'd0;
                        n_lastdot = 1'b0;
                    end else if (c == CH_MINUS) begin
                        res[cnt] = mk(K_LEXEME, TT_OP, c, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                        n_mode = M_NEG;
                    end else if (c == CH_QUOTE) begin
                        n_mode = M_STRING;
                    end else if (c == CH_EQ || c == CH_BANG) begin
                        res[cnt] = mk(K_LEXEME, TT_OP, c, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                        n_mode = M_DBL;
                    end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH) begin
                        res[cnt] = mk(K_LEXEME, TT_OP, c, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                        res[cnt] = mk(K_DONE, TT_OP, CH_NUL, r_line, r_col, E_BAD_NUMBER);
                        cnt = cnt + 2'd1;
                    end else begin
                        res[cnt] = mk(K_ERROR, TT_IDENT, CH_NUL, r_line, r_col,
                                      E_UNEXPECTED);
                        cnt = cnt + 2'd1;
                        n_mode = M_ERROR;
                    end
                end
            end
        end
        for (int i = 0; i < MAX_RES; i++) begin
            res[i].last = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_line    <= LINE_WIDTH'(1);
            r_col     <= COL_WIDTH'(1);
            r_tstart  <= COL_WIDTH'(1);
            r_dots    <= 2'd0;
            r_lastdot <= 1'b0;
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_count   <= '0;
            r_sub     <= 2'd0;
        end else begin
            r_mode    <= n_mode;
            r_line    <= n_line;
            r_col     <= n_col;
            r_tstart  <= n_tstart;
            r_dots    <= n_dots;
            r_lastdot <= n_lastdot;
            if (push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
                r_sub  <= 2'd0;
            end else if (out_acc) begin
                r_sub <= r_sub + 2'd1;
            end
            r_count <= r_count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= '{res: res, n: cnt};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result buffer count beyond its depth");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (head.n != 2'd0) && (r_sub < head.n))
        else $error("buffered result group is empty or overread");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_ERROR) |=> (r_mode == M_ERROR) && !$past(push))
        else $error("lexer left the error state or produced results after it");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_data.kind == K_ERROR) |-> o_out_data.last)
        else $error("error beat is not the final beat of its input");

endmodule

/* dv/source_line_tokenizer_checker.sv */
// Checker for the source line tokenizer: watches both channels, predicts the
// result beats of every accepted input beat and compares them in order.
// Depends on slt_pkg for the beat types and character constants.
`timescale 1ns / 1ps

module source_line_tokenizer_checker
    import slt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_beat   i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked
);

    typedef enum logic [3:0] {
        LX_IDLE,
        LX_IDENT,
        LX_NUMBER,
        LX_NEG,
        LX_DBL,
        LX_STRING,
        LX_ESCAPE,
        LX_COMMENT,
        LX_ERROR
    } t_lex_mode;

    // Fields that carry no meaning in a result beat are zero.
    localparam t_err NO_ERR = E_BAD_NUMBER;
    localparam t_tok NO_TOK = TT_IDENT;
    localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
    localparam logic [COL_WIDTH-1:0]  COL_MAX  = '1;

    t_lex_mode             mode      = LX_IDLE;
    logic [LINE_WIDTH-1:0] line_cnt  = 1;
    logic [COL_WIDTH-1:0]  col_cnt   = 1;
    logic [COL_WIDTH-1:0]  tok_col   = 1;
    logic [1:0]            dots      = 0;
    logic                  after_dot = 1'b0;

    t_out_beat   beat_results[$];
    t_out_beat   expected_results[$];
    int unsigned mismatches = 0;
    int unsigned checked    = 0;

    function automatic logic blank_char(input logic [7:0] c);
        return c == 8'd32 || c == CH_TAB || c == 8'd11 || c == 8'd12 || c == CH_CR;
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic void add_result(input t_kind k, input t_tok t, input logic [7:0] b,
                                       input logic [COL_WIDTH-1:0] col, input t_err e);
        t_out_beat r;
        if (beat_results.size() >= MAX_RES) return;
        r.kind          = k;
        r.token_type    = t;
        r.lexeme_byte   = b;
        r.line_number   = line_cnt;
        r.column_number = col;
        r.error_code    = e;
        r.last          = 1'b0;
        beat_results.push_back(r);
    endfunction

    function automatic void add_lexeme(input t_tok t, input logic [7:0] b,
                                       input logic [COL_WIDTH-1:0] col);
        add_result(K_LEXEME, t, b, col, NO_ERR);
    endfunction

    function automatic void add_done(input t_tok t, input logic [COL_WIDTH-1:0] col);
        add_result(K_DONE, t, 8'h00, col, NO_ERR);
    endfunction

    function automatic void raise_error(input t_err e, input logic [COL_WIDTH-1:0] col);
        add_result(K_ERROR, NO_TOK, 8'h00, col, e);
        mode = LX_ERROR;
    endfunction

    // Closes the token in progress; returns 0 when closing it is an error.
    function automatic logic close_token();
        case (mode)
            LX_IDENT: add_done(TT_IDENT, tok_col);
            LX_NUMBER: begin
                if (after_dot || dots >= 2'd2) begin
                    raise_error(E_BAD_NUMBER, tok_col);
                    return 1'b0;
                end
                add_done(dots == 2'd1 ? TT_FLOAT : TT_INT, tok_col);
            end
            LX_NEG, LX_DBL: add_done(TT_OP, tok_col);
            LX_STRING, LX_ESCAPE: begin
                raise_error(E_UNCLOSED, tok_col);
                return 1'b0;
            end
            default: ;
        endcase
        mode = LX_IDLE;
        return 1'b1;
    endfunction

    function automatic void open_token(input logic [7:0] c, input logic [COL_WIDTH-1:0] col);
        tok_col = col;
        case (c)
            CH_HASH:   mode = LX_COMMENT;
            CH_LBRACE: add_done(TT_LBRACE, col);
            CH_RBRACE: add_done(TT_RBRACE, col);
            CH_LPAREN: add_done(TT_LPAREN, col);
            CH_RPAREN: add_done(TT_RPAREN, col);
            CH_SEMI:   add_done(TT_SEMI, col);
            CH_MINUS: begin
                add_lexeme(TT_OP, c, col);
                mode = LX_NEG;
            end
            CH_QUOTE:  mode = LX_STRING;
            CH_EQ, CH_BANG: begin
                add_lexeme(TT_OP, c, col);
                mode = LX_DBL;
            end
            CH_PLUS, CH_STAR, CH_SLASH: begin
                add_lexeme(TT_OP, c, col);
                add_done(TT_OP, col);
            end
            default: begin
                if (letter_char(c)) begin
                    add_lexeme(TT_IDENT, c, col);
                    mode = LX_IDENT;
                end else if (digit_char(c)) begin
                    add_lexeme(TT_INT, c, col);
                    mode      = LX_NUMBER;
                    dots      = 0;
                    after_dot = 1'b0;
                end else if (!blank_char(c)) begin
                    raise_error(E_UNEXPECTED, col);
                end
            end
        endcase
    endfunction

    function automatic void take_char(input logic [7:0] c, input logic [COL_WIDTH-1:0] col);
        logic [7:0] xlat;
        case (mode)
            LX_IDENT: begin
                if (letter_char(c) || digit_char(c)) begin
                    add_lexeme(TT_IDENT, c, col);
                    return;
                end
            end
            LX_NUMBER: begin
                if (digit_char(c)) begin
                    add_lexeme(TT_INT, c, col);
                    after_dot = 1'b0;
                    return;
                end
                if (c == CH_DOT) begin
                    add_lexeme(TT_INT, c, col);
                    if (dots < 2'd2) dots++;
                    after_dot = 1'b1;
                    return;
                end
            end
            LX_NEG: begin
                if (digit_char(c)) begin
                    add_lexeme(TT_INT, c, col);
                    mode      = LX_NUMBER;
                    dots      = 0;
                    after_dot = 1'b0;
                    return;
                end
            end
            LX_DBL: begin
                if (c == CH_EQ) begin
                    add_lexeme(TT_OP, c, col);
                    add_done(TT_OP, tok_col);
                    mode = LX_IDLE;
                    return;
                end
            end
            LX_STRING: begin
                if (c == CH_QUOTE) begin
                    add_done(TT_STRING, tok_col);
                    mode = LX_IDLE;
                end else if (c == CH_BSLASH) begin
                    mode = LX_ESCAPE;
                end else begin
                    add_lexeme(TT_STRING, c, col);
                end
                return;
            end
            LX_ESCAPE: begin
                case (c)
                    CH_LOW_T: xlat = CH_TAB;
                    CH_LOW_R: xlat = CH_CR;
                    CH_LOW_N: xlat = CH_LF;
                    CH_QUOTE: xlat = CH_QUOTE;
                    CH_ZERO:  xlat = CH_NUL;
                    default: begin
                        raise_error(E_BAD_ESCAPE, col);
                        return;
                    end
                endcase
                add_lexeme(TT_STRING, xlat, col);
                mode = LX_STRING;
                return;
            end
            LX_COMMENT: return;
            default: ;
        endcase
        if (close_token()) open_token(c, col);
    endfunction

    function automatic void predict_beat(input t_in_beat b);
        t_out_beat r;
        beat_results.delete();
        if (mode == LX_ERROR) return;
        if (b.action) begin
            if (close_token()) begin
                mode = LX_IDLE;
                if (line_cnt != LINE_MAX) line_cnt++;
                col_cnt = 1;
            end
        end else begin
            take_char(b.char_byte, col_cnt);
            if (col_cnt != COL_MAX) col_cnt++;
        end
        for (int i = 0; i < beat_results.size(); i++) begin
            r = beat_results[i];
            r.last = (i == beat_results.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            mode      = LX_IDLE;
            line_cnt  = 1;
            col_cnt   = 1;
            tok_col   = 1;
            dots      = 0;
            after_dot = 1'b0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_beat(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting: kind %0d, type %0d",
                           i_out_data.kind, i_out_data.token_type);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, i_out_data.kind);
                    check_field("token_type", want.token_type, i_out_data.token_type);
                    check_field("lexeme_byte", want.lexeme_byte, i_out_data.lexeme_byte);
                    check_field("line_number", want.line_number, i_out_data.line_number);
                    check_field("column_number", want.column_number,
                                i_out_data.column_number);
                    check_field("error_code", want.error_code, i_out_data.error_code);
                    check_field("last", want.last, i_out_data.last);
                    checked++;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

/* dv/source_line_tokenizer_core_tb.sv */
// Testbench top for source_line_tokenizer_core: drives source bytes and
// end-of-line beats, stalls the result channel and gives the verdict.
// Depends on slt_pkg and source_line_tokenizer_checker.
`timescale 1ns / 1ps

module source_line_tokenizer_core_tb;
    import slt_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned sent       = 0;
    int unsigned burst_left = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    source_line_tokenizer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    source_line_tokenizer_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        #5000000;
        $display("FAIL source_line_tokenizer_core");
        $finish;
    end

    // Result side: segments of free flow, light and heavy stalls, and a long
    // hold-off now and then so that the result buffer fills and input stalls.
    initial begin : result_sink
        int unsigned seg_left     = 0;
        int unsigned seg_mode     = 0;
        int unsigned hold_left    = 0;
        int unsigned taken        = 0;
        int unsigned next_hold_at = 25;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) taken++;
            @(negedge clk);
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (taken >= next_hold_at) begin
                out_ready <= 1'b0;
                hold_left = 80;
                next_hold_at += 170;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(8, 40);
                end
                seg_left--;
                case (seg_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input logic act, input logic [7:0] c);
        int unsigned gap;
        t_in_beat b;
        b.action    = act;
        b.char_byte = c;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_beat(1'b0, c);
    endtask

    task automatic send_eol();
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] pick_letter();
        int unsigned n;
        n = $urandom_range(0, 52);
        if (n < 26) return 8'h61 + 8'(n);
        if (n < 52) return 8'h41 + 8'(n - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return 8'd32;
            1:       return CH_TAB;
            2:       return 8'd11;
            3:       return 8'd12;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 4))
            0:       return CH_LOW_T;
            1:       return CH_LOW_R;
            2:       return CH_LOW_N;
            3:       return CH_QUOTE;
            default: return CH_ZERO;
        endcase
    endfunction

    // An unsigned number opens with a blank so that it never runs on from an
    // identifier, where its dot would be an unexpected byte.
    task automatic send_number(input logic neg, input logic frac);
        if (neg) send_char(CH_MINUS);
        else send_char(pick_blank());
        repeat ($urandom_range(1, 4)) send_char(pick_digit());
        if (frac) begin
            send_char(CH_DOT);
            repeat ($urandom_range(1, 3)) send_char(pick_digit());
        end
        if ($urandom_range(0, 3) == 0) send_eol();
        else send_char(pick_blank());
    endtask

    task automatic send_token();
        logic [7:0] c;
        case ($urandom_range(0, 10))
            0, 1: begin
                send_char(pick_letter());
                repeat ($urandom_range(0, 6))
                    send_char($urandom_range(0, 2) == 0 ? pick_digit() : pick_letter());
            end
            2, 3: send_number($urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
            4: begin
                send_char(CH_QUOTE);
                repeat ($urandom_range(0, 8)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 5) == 0) begin
                        send_char(CH_BSLASH);
                        send_char(pick_escape());
                    end else begin
                        send_char(c);
                    end
                end
                send_char(CH_QUOTE);
            end
            5: begin
                case ($urandom_range(0, 6))
                    0: send_char(CH_PLUS);
                    1: send_char(CH_STAR);
                    2: send_char(CH_SLASH);
                    3: send_char(CH_MINUS);
                    4: send_char(CH_EQ);
                    5: send_char(CH_BANG);
                    default: begin
                        send_char($urandom_range(0, 1) == 0 ? CH_EQ : CH_BANG);
                        send_char(CH_EQ);
                    end
                endcase
            end
            6: begin
                case ($urandom_range(0, 4))
                    0:       send_char(CH_LBRACE);
                    1:       send_char(CH_RBRACE);
                    2:       send_char(CH_LPAREN);
                    3:       send_char(CH_RPAREN);
                    default: send_char(CH_SEMI);
                endcase
            end
            7: repeat ($urandom_range(1, 3)) send_char(pick_blank());
            8: begin
                send_char(CH_HASH);
                repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(0, 255)));
                send_eol();
            end
            default: send_eol();
        endcase
    endtask

    task automatic send_error_case(input t_err which);
        logic [7:0] c;
        case (which)
            E_BAD_NUMBER: begin
                if ($urandom_range(0, 1) == 0) send_text("12.");
                else send_text("1.2.3");
                send_char(pick_blank());
            end
            E_BAD_ESCAPE: begin
                send_char(CH_QUOTE);
                send_text("ab");
                send_char(CH_BSLASH);
                do c = 8'($urandom_range(0, 255));
                while (c inside {CH_LOW_T, CH_LOW_R, CH_LOW_N, CH_QUOTE, CH_ZERO});
                send_char(c);
            end
            E_UNCLOSED: begin
                send_char(CH_QUOTE);
                send_text("x");
                if ($urandom_range(0, 1) == 0) send_char(CH_BSLASH);
                send_eol();
            end
            default: begin
                if ($urandom_range(0, 1) == 0) send_char(pick_letter());
                case ($urandom_range(0, 4))
                    0:       send_char(CH_LF);
                    1:       send_char(CH_DOT);
                    2:       send_char(8'h80 | 8'($urandom_range(0, 127)));
                    3:       send_char(8'h40);
                    default: send_char(CH_BSLASH);
                endcase
            end
        endcase
    endtask

    initial begin : stimulus
        int unsigned random_start;
        int unsigned drain;
        t_err        closing_err;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("aZ_9 -7 3.25-{}();");
        send_eol();
        send_text("==!=!+*/=");
        send_eol();
        send_char(CH_QUOTE);
        send_text("\\t\\r\\n\\\"\\0");
        send_char(CH_NUL);
        send_char(8'hFF);
        send_char(CH_QUOTE);
        send_char(CH_TAB);
        send_char(8'd11);
        send_char(8'd12);
        send_char(CH_CR);
        send_char(CH_HASH);
        send_char(8'hFF);
        send_char(CH_LF);
        send_eol();

        random_start = sent;
        while (sent - random_start < 180) send_token();
        send_eol();

        closing_err = t_err'($urandom_range(0, 3));
        send_error_case(closing_err);
        repeat (12) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        @(negedge clk);
        in_valid <= 1'b0;

        drain = 0;
        do begin
            @(posedge clk);
            drain++;
        end while (pending != 0 && drain < 5000);
        repeat (20) @(posedge clk);

        if (pending != 0) $error("%0d expected result beats never arrived", pending);
        $display("Covered %0d input beats and %0d result beats, with every token kind,",
                 sent, checked);
        $display("escapes, comments, a long output hold-off and a closing %s.",
                 closing_err.name());
        if (fail_count == 0 && pending == 0) begin
            $display("PASS source_line_tokenizer_core");
        end else begin
            $display("FAIL source_line_tokenizer_core");
        end
        $finish;
    end

endmodule
